// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every edge outside reset
`define CHK_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// cond must never be seen outside reset
`define CHK_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define CHK_PROP(label, clk, rst, prop, msg)
`define CHK_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/tceq_pkg.sv =====
package tceq_pkg;

  localparam int DEPTH       = 64;
  localparam int HANDLE_BITS = 32;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // operation codes on the input word
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  // command kinds handed from front to back
  localparam logic [1:0] K_ENQ  = 2'd0;
  localparam logic [1:0] K_DEQ  = 2'd1;
  localparam logic [1:0] K_STOP = 2'd2;
  localparam logic [1:0] K_BAD  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_SHUTDOWN = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_ACK_QUOTA = 2'd0;
  localparam logic [1:0] CFG_ACK_CAP   = 2'd1;
  localparam logic [1:0] CFG_DATA_CAP  = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic                   sel;
    logic [HANDLE_BITS-1:0] handle;
    logic [15:0]            length;
  } cmd_t;

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [15:0]            length;
  } entry_t;

  // clamp a capacity register into 1..DEPTH
  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] res;
    if (cap == '0) res = CNT_W'(1);
    else if (cap > CNT_W'(DEPTH)) res = CNT_W'(DEPTH);
    else res = cap;
    return res;
  endfunction

  // advance a ring pointer, wrapping at or past the capacity
  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(p) + CNT_W'(1);
    return (inc >= cap) ? '0 : PTR_W'(inc);
  endfunction

endpackage

// ===== hw/rtl/tceq_front.sv =====
module tceq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [47:0]   s_tdata,   // packet_handle[31:0], packet_length[47:32]
  input  logic [2:0]    s_tuser,   // operation[1:0], queue_select[2]
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output tceq_pkg::cmd_t cmd
);
  import tceq_pkg::*;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cls;
  logic       push;
  logic       pop;

  // classify: zero-length enqueues and the unused operation code are marked bad here
  always_comb begin
    cls.sel    = s_tuser[2];
    cls.handle = HANDLE_BITS'(s_tdata[31:0]);
    cls.length = s_tdata[47:32];
    unique case (s_tuser[1:0])
      OP_ENQ:  cls.kind = (s_tdata[47:32] == 16'd0) ? K_BAD : K_ENQ;
      OP_DEQ:  cls.kind = K_DEQ;
      OP_STOP: cls.kind = K_STOP;
      default: cls.kind = K_BAD;
    endcase
  end

  assign s_tready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/tceq_back.sv =====
module tceq_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  tceq_pkg::cmd_t cmd,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [79:0]    m_tdata,
  output logic [3:0]     m_tuser
);
  import tceq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  entry_t ack_mem  [DEPTH];
  entry_t data_mem [DEPTH];
  entry_t ack_rd;
  entry_t data_rd;

  logic             state;
  logic [7:0]       quota_limit;
  logic [CNT_W-1:0] ack_capacity;
  logic [CNT_W-1:0] data_capacity;
  logic [PTR_W-1:0] ack_head, ack_tail, data_head, data_tail;
  logic [CNT_W-1:0] ack_count, data_count, ack_peak, data_peak;
  logic             ack_stopped, data_stopped;
  logic [7:0]       ack_run;
  logic [2:0]       pend_status;
  logic             pend_pop;
  logic             pend_ack;

  logic             exec;
  logic [CNT_W-1:0] acap, dcap;
  logic             spent;
  logic             pop_data, pop_ack;
  logic             enq_ack, enq_data;
  logic [2:0]       status;

  assign acap      = eff_cap(ack_capacity);
  assign dcap      = eff_cap(data_capacity);
  assign cmd_ready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign exec      = cmd_valid && cmd_ready;
  assign spent     = (ack_run >= quota_limit);

  always_comb begin
    pop_data = 1'b0;
    pop_ack  = 1'b0;
    enq_ack  = 1'b0;
    enq_data = 1'b0;
    status   = ST_INVALID;
    unique case (cmd.kind)
      K_ENQ: begin
        if (cmd.sel ? data_stopped : ack_stopped) begin
          status = ST_SHUTDOWN;
        end else if (cmd.sel ? (data_count >= dcap) : (ack_count >= acap)) begin
          status = ST_FULL;
        end else begin
          status   = ST_OK;
          enq_data = cmd.sel;
          enq_ack  = !cmd.sel;
        end
      end
      K_DEQ: begin
        // data goes first once the ack run is spent, or when no ack waits
        pop_data = (data_count != '0) && (spent || (ack_count == '0));
        pop_ack  = (ack_count != '0) && !pop_data;
        if (pop_data || pop_ack) status = ST_OK;
        else if (ack_stopped && data_stopped) status = ST_SHUTDOWN;
        else status = ST_EMPTY;
      end
      K_STOP: status = ST_OK;
      default: status = ST_INVALID;
    endcase
  end

  // descriptor stores: write at tail, read at head
  always_ff @(posedge clk) begin
    if (exec && enq_ack) ack_mem[ack_tail] <= '{handle: cmd.handle, length: cmd.length};
    if (exec) ack_rd <= ack_mem[ack_head];
  end

  always_ff @(posedge clk) begin
    if (exec && enq_data) data_mem[data_tail] <= '{handle: cmd.handle, length: cmd.length};
    if (exec) data_rd <= data_mem[data_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quota_limit   <= 8'd4;
      ack_capacity  <= CNT_W'(DEPTH);
      data_capacity <= CNT_W'(DEPTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACK_QUOTA: quota_limit   <= cfg_data;
        CFG_ACK_CAP:   ack_capacity  <= CNT_W'(cfg_data);
        CFG_DATA_CAP:  data_capacity <= CNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ack_head     <= '0;
      ack_tail     <= '0;
      ack_count    <= '0;
      ack_peak     <= '0;
      data_head    <= '0;
      data_tail    <= '0;
      data_count   <= '0;
      data_peak    <= '0;
      ack_stopped  <= 1'b0;
      data_stopped <= 1'b0;
      ack_run      <= '0;
      pend_status  <= ST_OK;
      pend_pop     <= 1'b0;
      pend_ack     <= 1'b0;
    end else if (exec) begin
      state       <= S_RESP;
      pend_status <= status;
      pend_pop    <= pop_data || pop_ack;
      pend_ack    <= pop_ack;
      if (enq_ack) begin
        ack_tail  <= step_ptr(ack_tail, acap);
        ack_count <= ack_count + CNT_W'(1);
        if (ack_count + CNT_W'(1) > ack_peak) ack_peak <= ack_count + CNT_W'(1);
      end
      if (enq_data) begin
        data_tail  <= step_ptr(data_tail, dcap);
        data_count <= data_count + CNT_W'(1);
        if (data_count + CNT_W'(1) > data_peak) data_peak <= data_count + CNT_W'(1);
      end
      if (pop_ack) begin
        ack_head  <= step_ptr(ack_head, acap);
        ack_count <= ack_count - CNT_W'(1);
        if (!spent) ack_run <= ack_run + 8'd1;
      end
      if (pop_data) begin
        data_head  <= step_ptr(data_head, dcap);
        data_count <= data_count - CNT_W'(1);
        ack_run    <= '0;
      end
      if (cmd.kind == K_STOP) begin
        if (cmd.sel) data_stopped <= 1'b1;
        else ack_stopped <= 1'b1;
      end
    end else begin
      state <= S_IDLE;
    end
  end

  // result register: loaded in the cycle after execute, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESP) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP) begin
      m_tuser <= {pend_ack, pend_status};
      m_tdata <= {4'd0, 7'(data_peak), 7'(ack_peak), 7'(data_count), 7'(ack_count),
                  !pend_pop ? 16'd0 : (pend_ack ? ack_rd.length : data_rd.length),
                  !pend_pop ? 32'd0 : 32'(pend_ack ? ack_rd.handle : data_rd.handle)};
    end
  end

endmodule

// ===== hw/rtl/two_class_egress_queue_ack_quota.sv =====
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: handle, length; tuser: operation, queue_select
// m_*      out  m_tvalid/m_tready  tdata: descriptor, levels, high water; tuser: status, from_ack
// cfg_*    in   cfg_we             cfg_index selects quota / ack cap / data cap
//
// An accepted word waits in the two-entry front queue until the back end executes it;
// the back end registers the result in the cycle after it executes the word.
// The back end takes no new word while it loads a result or holds one not yet taken,
// so execute and result-load alternate; the descriptor store read is registered.
// rst is synchronous; queues come up empty, quota 4, both capacities 64.
// An output stall backs up into the front queue; a full front queue drops s_tready.
`include "assert_macros.svh"

module two_class_egress_queue_ack_quota (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // packet_handle[31:0], packet_length[47:32]
  input  logic [2:0]  s_tuser,   // operation[1:0], queue_select[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_handle[31:0], out_length[47:32], ack_level[54:48], data_level[61:55],
  // ack_high_water[68:62], data_high_water[75:69], zero[79:76]
  output logic [79:0] m_tdata,
  output logic [3:0]  m_tuser,   // status[2:0], out_from_ack[3]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tceq_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  logic [2:0]       out_status;
  logic             out_ack;
  logic             out_failed;
  logic [47:0]      out_desc;
  logic [CNT_W-1:0] ack_lvl, data_lvl, ack_hw, data_hw;

  tceq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tceq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  assign out_status = m_tuser[2:0];
  assign out_ack    = m_tuser[3];
  assign out_failed = m_tvalid && (out_status != ST_OK);
  assign out_desc   = m_tdata[47:0];
  assign ack_lvl    = m_tdata[54:48];
  assign data_lvl   = m_tdata[61:55];
  assign ack_hw     = m_tdata[68:62];
  assign data_hw    = m_tdata[75:69];

  `CHK_PROP(a_ack_ok, clk, rst, (m_tvalid && out_ack) |-> (out_status == ST_OK), "ack not ok")
  `CHK_PROP(a_fail_zero, clk, rst, out_failed |-> ((out_desc == '0) && !out_ack), "stray descriptor")
  `CHK_NEVER(a_ack_peak, clk, rst, m_tvalid && (ack_lvl > ack_hw), "ack level above high water")
  `CHK_NEVER(a_data_peak, clk, rst, m_tvalid && (data_lvl > data_hw), "data level above high water")

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import tceq_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam logic       SEL_ACK   = 1'b0;
  localparam logic       SEL_DATA  = 1'b1;

  typedef struct packed {
    logic [1:0]             operation;
    logic                   queue_select;
    logic [HANDLE_BITS-1:0] packet_handle;
    logic [15:0]            packet_length;
  } egress_word_t;

  typedef struct packed {
    logic [2:0]             status;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [15:0]            out_length;
    logic                   out_from_ack;
    logic [CNT_W-1:0]       ack_level;
    logic [CNT_W-1:0]       data_level;
    logic [CNT_W-1:0]       ack_high_water;
    logic [CNT_W-1:0]       data_high_water;
  } egress_result_t;

  typedef struct {
    egress_word_t   word;
    bit             typed;
    egress_result_t want;
  } script_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata   = '0;  // packet_handle[31:0], packet_length[47:32]
  logic [2:0]  s_tuser   = '0;  // operation[1:0], queue_select[2]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  // out_handle[31:0], out_length[47:32], ack_level[54:48], data_level[61:55],
  // ack_high_water[68:62], data_high_water[75:69], zero[79:76]
  logic [79:0] m_tdata;
  logic [3:0]  m_tuser;         // status[2:0], out_from_ack[3]
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  two_class_egress_queue_ack_quota i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow of both rings, indexed by queue_select
  logic [HANDLE_BITS-1:0] ring_handle  [2][DEPTH];
  logic [15:0]            ring_length  [2][DEPTH];
  bit                     ring_written [2][DEPTH];
  int                     ring_head    [2];
  int                     ring_tail    [2];
  int                     ring_count   [2];
  int                     ring_peak    [2];
  bit                     ring_stopped [2];
  int                     ack_run;
  int                     quota_reg    = 4;
  int                     cap_reg      [2] = '{64, 64};

  egress_result_t due_results [$];
  script_row_t    script [$];
  int             mismatches;
  int             quiet_cycles;
  int             in_left, out_left;
  bit             in_calm, out_calm;

  function automatic int slots_of(int q);
    if (cap_reg[q] == 0) return 1;
    if (cap_reg[q] > DEPTH) return DEPTH;
    return cap_reg[q];
  endfunction

  function automatic int advance(int p, int q);
    return (p + 1 >= slots_of(q)) ? 0 : p + 1;
  endfunction

  // queue a dequeue would take from, or -1 when both are empty
  function automatic int deq_source();
    bit spent;
    spent = ack_run >= quota_reg;
    if (spent && ring_count[SEL_DATA] != 0) return SEL_DATA;
    if (ring_count[SEL_ACK] != 0) return SEL_ACK;
    if (!spent && ring_count[SEL_DATA] != 0) return SEL_DATA;
    return -1;
  endfunction

  function automatic egress_result_t egress_outcome(egress_word_t w);
    egress_result_t r;
    int q;
    int src;
    bit spent;
    r = '0;
    r.status = ST_INVALID;
    q = int'(w.queue_select);
    case (w.operation)
      OP_ENQ: begin
        if (w.packet_length == '0) begin
          r.status = ST_INVALID;
        end else if (ring_stopped[q]) begin
          r.status = ST_SHUTDOWN;
        end else if (ring_count[q] >= slots_of(q)) begin
          r.status = ST_FULL;
        end else begin
          ring_handle[q][ring_tail[q]]  = w.packet_handle;
          ring_length[q][ring_tail[q]]  = w.packet_length;
          ring_written[q][ring_tail[q]] = 1'b1;
          ring_tail[q] = advance(ring_tail[q], q);
          ring_count[q]++;
          if (ring_count[q] > ring_peak[q]) ring_peak[q] = ring_count[q];
          r.status = ST_OK;
        end
      end
      OP_DEQ: begin
        spent = ack_run >= quota_reg;
        src = deq_source();
        if (src < 0) begin
          r.status = (ring_stopped[SEL_ACK] && ring_stopped[SEL_DATA]) ? ST_SHUTDOWN : ST_EMPTY;
        end else begin
          r.status     = ST_OK;
          r.out_handle = ring_handle[src][ring_head[src]];
          r.out_length = ring_length[src][ring_head[src]];
          ring_head[src] = advance(ring_head[src], src);
          ring_count[src]--;
          if (src == SEL_ACK) begin
            r.out_from_ack = 1'b1;
            // past the quota an ack still goes out, but the run holds
            if (!spent) ack_run = (ack_run + 1) & 8'hFF;
          end else begin
            ack_run = 0;
          end
        end
      end
      OP_STOP: begin
        ring_stopped[q] = 1'b1;
        r.status = ST_OK;
      end
      default: ;
    endcase
    r.ack_level       = CNT_W'(ring_count[SEL_ACK]);
    r.data_level      = CNT_W'(ring_count[SEL_DATA]);
    r.ack_high_water  = CNT_W'(ring_peak[SEL_ACK]);
    r.data_high_water = CNT_W'(ring_peak[SEL_DATA]);
    return r;
  endfunction

  // idle cycles before the next word; alternate calm stretches with busy ones
  function automatic int draw_gap(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(10, 60);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] random_cap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(1, 8));
      6, 7: return 8'($urandom_range(9, 64));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, logic [HANDLE_BITS-1:0] want,
                                      logic [HANDLE_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_row(logic [1:0] op, logic sel, logic [HANDLE_BITS-1:0] handle,
                         logic [15:0] length);
    script_row_t row;
    row.word.operation     = op;
    row.word.queue_select  = sel;
    row.word.packet_handle = handle;
    row.word.packet_length = length;
    row.typed = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endtask

  task automatic add_checked(logic [1:0] op, logic sel, logic [HANDLE_BITS-1:0] handle,
                             logic [15:0] length, logic [2:0] status,
                             logic [CNT_W-1:0] ack_lvl, logic [CNT_W-1:0] data_lvl,
                             logic [CNT_W-1:0] ack_hw, logic [CNT_W-1:0] data_hw);
    add_row(op, sel, handle, length);
    script[script.size() - 1].typed                = 1'b1;
    script[script.size() - 1].want.status          = status;
    script[script.size() - 1].want.ack_level       = ack_lvl;
    script[script.size() - 1].want.data_level      = data_lvl;
    script[script.size() - 1].want.ack_high_water  = ack_hw;
    script[script.size() - 1].want.data_high_water = data_hw;
  endtask

  task automatic issue_word(egress_word_t w, bit typed, egress_result_t want);
    egress_result_t predicted;
    int gap;
    gap = draw_gap(in_left, in_calm);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {w.packet_length, w.packet_handle};
    s_tuser  <= {w.queue_select, w.operation};
    do @(posedge clk); while (!s_tready);
    predicted = egress_outcome(w);
    due_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(logic [1:0] index, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    case (index)
      CFG_ACK_QUOTA: quota_reg = value;
      CFG_ACK_CAP:   cap_reg[SEL_ACK] = value[6:0];
      CFG_DATA_CAP:  cap_reg[SEL_DATA] = value[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [7:0] quota, logic [7:0] ack_cap, logic [7:0] data_cap);
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    write_reg(CFG_ACK_QUOTA, quota);
    write_reg(CFG_ACK_CAP, ack_cap);
    write_reg(CFG_DATA_CAP, data_cap);
    write_reg(CFG_SPARE, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int items, int enq_pct, bit stops_on);
    egress_word_t w;
    egress_result_t none;
    int roll;
    int src;
    none = '0;
    repeat (items) begin
      roll = $urandom_range(0, 99);
      w.queue_select  = 1'($urandom_range(0, 1));
      w.packet_handle = $urandom;
      case ($urandom_range(0, 19))
        0: w.packet_length = '0;
        1: w.packet_length = 16'hFFFF;
        2: w.packet_length = 16'h0001;
        default: w.packet_length = 16'($urandom_range(1, 65535));
      endcase
      if (stops_on && roll < 4) w.operation = OP_STOP;
      else if (roll < 6) w.operation = OP_UNUSED;
      else if (roll < 6 + enq_pct * 94 / 100) w.operation = OP_ENQ;
      else w.operation = OP_DEQ;
      // never pop a slot that was never written; enqueue instead
      if (w.operation == OP_DEQ) begin
        src = deq_source();
        if (src >= 0 && !ring_written[src][ring_head[src]]) w.operation = OP_ENQ;
      end
      issue_word(w, 1'b0, none);
    end
  endtask

  task automatic stop_queue(logic sel);
    egress_word_t w;
    egress_result_t none;
    none = '0;
    w.operation     = OP_STOP;
    w.queue_select  = sel;
    w.packet_handle = $urandom;
    w.packet_length = 16'($urandom);
    issue_word(w, 1'b0, none);
  endtask

  initial begin
    add_checked(OP_DEQ,    SEL_ACK,  32'h0,        16'h0,    ST_EMPTY,   0, 0, 0, 0);
    add_checked(OP_UNUSED, SEL_DATA, 32'hFFFFFFFF, 16'hFFFF, ST_INVALID, 0, 0, 0, 0);
    add_checked(OP_ENQ,    SEL_ACK,  32'hFFFFFFFF, 16'h0,    ST_INVALID, 0, 0, 0, 0);
    add_checked(OP_ENQ,    SEL_ACK,  32'hFFFFFFFF, 16'hFFFF, ST_OK,      1, 0, 1, 0);
    add_checked(OP_ENQ,    SEL_ACK,  32'h0,        16'h0001, ST_OK,      2, 0, 2, 0);
    add_row(OP_ENQ, SEL_ACK, 32'h12345678, 16'h0040);
    add_row(OP_ENQ, SEL_ACK, 32'h00000001, 16'h7FFF);
    add_row(OP_ENQ, SEL_ACK, 32'h80000000, 16'h0001);
    // four acks use up the quota; the fifth goes out with data empty
    repeat (5) add_row(OP_DEQ, SEL_ACK, 32'h0, 16'h0);
    add_checked(OP_DEQ,    SEL_ACK,  32'h0,        16'h0,    ST_EMPTY,   0, 0, 5, 0);
    add_checked(OP_ENQ,    SEL_DATA, 32'hA5A55A5A, 16'h8000, ST_OK,      0, 1, 5, 1);
    add_row(OP_ENQ, SEL_DATA, 32'h5A5AA5A5, 16'h00FF);
    add_row(OP_ENQ, SEL_ACK,  32'hFEDCBA98, 16'h1234);
    // spent run: data first, then ack, then data with the ack queue empty
    repeat (3) add_row(OP_DEQ, SEL_DATA, 32'h0, 16'h0);
    add_checked(OP_ENQ,    SEL_DATA, 32'h0,        16'h0,    ST_INVALID, 0, 0, 5, 2);
    add_checked(OP_UNUSED, SEL_ACK,  32'h0,        16'h0,    ST_INVALID, 0, 0, 5, 2);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) issue_word(script[i].word, script[i].typed, script[i].want);

    configure(8'd4, 8'd64, 8'd64);
    random_phase(250, 90, 1'b0);
    configure(8'd1, 8'd1, 8'd1);
    random_phase(120, 50, 1'b0);
    configure(8'd255, 8'd0, 8'd2);
    random_phase(120, 45, 1'b0);
    configure(8'd0, 8'hFF, 8'h80);
    random_phase(150, 55, 1'b0);
    repeat (6) begin
      configure(8'($urandom_range(0, 255)), random_cap(), random_cap());
      random_phase(120, $urandom_range(30, 70), 1'b0);
    end

    // shutdown is sticky until reset, so it comes last
    configure(8'($urandom_range(1, 8)), 8'd6, 8'd6);
    random_phase(50, 60, 1'b0);
    stop_queue(SEL_DATA);
    random_phase(50, 60, 1'b0);
    stop_queue(SEL_ACK);
    random_phase(60, 25, 1'b1);

    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    egress_result_t want;
    egress_result_t got;
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = draw_gap(out_left, out_calm);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.out_handle      = m_tdata[31:0];
      got.out_length      = m_tdata[47:32];
      got.ack_level       = m_tdata[54:48];
      got.data_level      = m_tdata[61:55];
      got.ack_high_water  = m_tdata[68:62];
      got.data_high_water = m_tdata[75:69];
      got.status          = m_tuser[2:0];
      got.out_from_ack    = m_tuser[3];
      if (due_results.size() == 0) begin
        $error("result word with no pending operation, status %0d", got.status);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("out_handle", want.out_handle, got.out_handle);
        check_field("out_length", want.out_length, got.out_length);
        check_field("out_from_ack", want.out_from_ack, got.out_from_ack);
        check_field("ack_level", want.ack_level, got.ack_level);
        check_field("data_level", want.data_level, got.data_level);
        check_field("ack_high_water", want.ack_high_water, got.ack_high_water);
        check_field("data_high_water", want.data_high_water, got.data_high_water);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tceq_pkg.sv
hw/rtl/tceq_front.sv
hw/rtl/tceq_back.sv
hw/rtl/two_class_egress_queue_ack_quota.sv
test/tb.sv
